@@ hdl/krbt_pkg.sv @@
// krbt_pkg: shared types and constants for the keyed ring buffer table.
// Holds beat layouts, command and status codes, FSM states and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package krbt_pkg;

    // field widths
    localparam int CMD_W = 3;
    localparam int KEY_W = 16;
    localparam int PAY_W = 32;
    localparam int ST_W  = 3;
    localparam int OCC_W = 5;
    localparam int CFG_W = 5;

    // depth register value after reset
    localparam int DEPTH_RST = 16;

    // input beat layout, lowest bit first
    localparam int IN_CMD_LSB  = 0;
    localparam int IN_KEY_LSB  = IN_CMD_LSB + CMD_W;
    localparam int IN_NKEY_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_PAY_LSB  = IN_NKEY_LSB + KEY_W;
    localparam int IN_USED_W   = IN_PAY_LSB + PAY_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // output beat layout, lowest bit first
    localparam int OUT_ST_LSB  = 0;
    localparam int OUT_KEY_LSB = OUT_ST_LSB + ST_W;
    localparam int OUT_PAY_LSB = OUT_KEY_LSB + KEY_W;
    localparam int OUT_OCC_LSB = OUT_PAY_LSB + PAY_W;
    localparam int OUT_USED_W  = OUT_OCC_LSB + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_ADD    = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_DELETE = 3'd4,
        CMD_UPDATE = 3'd5,
        CMD_REKEY  = 3'd6,
        CMD_CLEAR  = 3'd7
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_DUP      = 3'd4,
        ST_UNKNOWN  = 3'd5
    } t_status;

    // read port address source
    typedef enum logic [1:0] {
        RD_SCAN,
        RD_HIT,
        RD_RSLOT
    } t_rd_sel;

    // write data source
    typedef enum logic [1:0] {
        WS_INPUT,
        WS_NKEY,
        WS_READ
    } t_wsrc;

    // result key/payload source
    typedef enum logic [1:0] {
        RES_ZERO,
        RES_RD,
        RES_KEY_PAY,
        RES_NKEY_RD
    } t_res_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_LK_RD,
        S_LOAD_RD,
        S_UPD_WR,
        S_DEL_RD_HIT,
        S_DEL_RD_OLD,
        S_DEL_WR,
        S_LOAD_NKEY,
        S_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     cap_in;
        logic     clear;
        logic     scan_start;
        logic     scan_nkey;
        logic     scan_step;
        logic     hit_latch;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_key;
        logic     wr_pay;
        logic     wr_at_hit;
        t_wsrc    wr_src;
        logic     push_adv;
        logic     pop_adv;
        logic     res_load;
        t_status  res_status;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic empty;
        logic scan_done;
        logic match;
        logic out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/krbt_dp.sv @@
// krbt_dp: datapath of the keyed ring buffer table - key and payload
// stores, ring pointers, scan counter, result and output registers.
// Depends on krbt_pkg; driven by krbt_ctrl through t_dp_cmd.
`default_nettype none

module krbt_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [krbt_pkg::IN_TDATA_W-1:0] i_in_tdata,
    input  wire logic                           i_cfg_we,
    input  wire logic [krbt_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire krbt_pkg::t_dp_cmd              i_cmd,
    output krbt_pkg::t_dp_stat                  o_stat,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [krbt_pkg::OUT_TDATA_W-1:0]    o_out_tdata
);
    import krbt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = ((AW > OCC_W) ? AW : OCC_W) + 1;
    localparam logic [OCC_W-1:0] ACT_RST =
        OCC_W'((DEPTH < DEPTH_RST) ? DEPTH : DEPTH_RST);

    // slot after s, wrapping at the active depth
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] s,
                                             input logic [OCC_W-1:0] act);
        logic [CW-1:0] inc;
        begin
            inc = CW'(s) + CW'(1);
            if (inc >= CW'(act)) begin
                return '0;
            end
            return inc[AW-1:0];
        end
    endfunction

    // stores, undefined until written
    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [PAY_W-1:0] pay_mem [DEPTH];

    // captured input beat
    t_cmd             r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_nkey;
    logic [PAY_W-1:0] r_pay;

    // ring state
    logic [AW-1:0]    r_wslot;
    logic [AW-1:0]    r_rslot;
    logic [OCC_W-1:0] r_count;
    logic [OCC_W-1:0] r_active;
    logic [CFG_W-1:0] r_depth_cfg;
    logic [OCC_W-1:0] depth_clamped;

    // scan state
    logic [AW-1:0]    r_scan_slot;
    logic [OCC_W-1:0] r_scan_left;
    logic [KEY_W-1:0] r_search_key;
    logic [AW-1:0]    r_rd_slot;
    logic [AW-1:0]    r_hit_slot;

    // read port
    logic [AW-1:0]    rd_addr;
    logic [KEY_W-1:0] r_key_rd;
    logic [PAY_W-1:0] r_pay_rd;

    // write port
    logic [AW-1:0]    wr_addr;
    logic [KEY_W-1:0] wr_key_data;
    logic [PAY_W-1:0] wr_pay_data;

    // result and output
    t_status          r_res_status;
    logic [KEY_W-1:0] r_res_key;
    logic [PAY_W-1:0] r_res_pay;
    logic             r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_tdata;

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_cmd  <= t_cmd'(i_in_tdata[IN_CMD_LSB +: CMD_W]);
            r_key  <= i_in_tdata[IN_KEY_LSB +: KEY_W];
            r_nkey <= i_in_tdata[IN_NKEY_LSB +: KEY_W];
            r_pay  <= i_in_tdata[IN_PAY_LSB +: PAY_W];
        end
    end

    // depth clamp: zero acts as one, above DEPTH acts as DEPTH
    always_comb begin
        if (r_depth_cfg == '0) begin
            depth_clamped = OCC_W'(1);
        end else if (CW'(r_depth_cfg) > CW'(DEPTH)) begin
            depth_clamped = OCC_W'(DEPTH);
        end else begin
            depth_clamped = OCC_W'(r_depth_cfg);
        end
    end

    // depth register and ring pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_cfg <= CFG_W'(DEPTH_RST);
            r_active    <= ACT_RST;
            r_wslot     <= '0;
            r_rslot     <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_depth_cfg <= i_cfg_wdata;
            end
            if (i_cmd.clear) begin
                r_active <= depth_clamped;
                r_wslot  <= '0;
                r_rslot  <= '0;
                r_count  <= '0;
            end else begin
                if (i_cmd.push_adv) begin
                    r_wslot <= f_next(r_wslot, r_active);
                    r_count <= r_count + OCC_W'(1);
                end
                if (i_cmd.pop_adv) begin
                    r_rslot <= f_next(r_rslot, r_active);
                    r_count <= r_count - OCC_W'(1);
                end
            end
        end
    end

    // oldest-first key scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_scan_slot  <= r_rslot;
            r_scan_left  <= r_count;
            r_search_key <= i_cmd.scan_nkey ? r_nkey : r_key;
        end else if (i_cmd.scan_step) begin
            r_scan_slot <= f_next(r_scan_slot, r_active);
            r_scan_left <= r_scan_left - OCC_W'(1);
        end
        if (i_cmd.scan_step) begin
            r_rd_slot <= r_scan_slot;
        end
        if (i_cmd.hit_latch) begin
            r_hit_slot <= r_rd_slot;
        end
    end

    // read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_SCAN:  rd_addr = r_scan_slot;
            RD_HIT:   rd_addr = r_hit_slot;
            RD_RSLOT: rd_addr = r_rslot;
            default:  rd_addr = r_scan_slot;
        endcase
    end

    // write address and data select
    always_comb begin
        wr_addr = i_cmd.wr_at_hit ? r_hit_slot : r_wslot;
        unique case (i_cmd.wr_src)
            WS_INPUT: begin
                wr_key_data = r_key;
                wr_pay_data = r_pay;
            end
            WS_NKEY: begin
                wr_key_data = r_nkey;
                wr_pay_data = r_pay;
            end
            WS_READ: begin
                wr_key_data = r_key_rd;
                wr_pay_data = r_pay_rd;
            end
            default: begin
                wr_key_data = r_key;
                wr_pay_data = r_pay;
            end
        endcase
    end

    // stores: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_key) begin
            key_mem[wr_addr] <= wr_key_data;
        end
        if (i_cmd.rd_en) begin
            r_key_rd <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pay) begin
            pay_mem[wr_addr] <= wr_pay_data;
        end
        if (i_cmd.rd_en) begin
            r_pay_rd <= pay_mem[rd_addr];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            unique case (i_cmd.res_sel)
                RES_ZERO: begin
                    r_res_key <= '0;
                    r_res_pay <= '0;
                end
                RES_RD: begin
                    r_res_key <= r_key_rd;
                    r_res_pay <= r_pay_rd;
                end
                RES_KEY_PAY: begin
                    r_res_key <= r_key;
                    r_res_pay <= r_pay;
                end
                RES_NKEY_RD: begin
                    r_res_key <= r_nkey;
                    r_res_pay <= r_pay_rd;
                end
                default: begin
                    r_res_key <= '0;
                    r_res_pay <= '0;
                end
            endcase
        end
    end

    // output register, occupancy taken once the command has settled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_tdata <= OUT_TDATA_W'({r_count, r_res_pay, r_res_key, r_res_status});
        end
    end

    // status to controller
    always_comb begin
        o_stat.cmd       = r_cmd;
        o_stat.full      = (r_count >= r_active);
        o_stat.empty     = (r_count == '0);
        o_stat.scan_done = (r_scan_left == '0);
        o_stat.match     = (r_key_rd == r_search_key);
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_tdata;

endmodule

`default_nettype wire

@@ hdl/krbt_ctrl.sv @@
// krbt_ctrl: command sequencer of the keyed ring buffer table.
// Decodes each accepted beat and steps the datapath through scans and
// read-modify-write of one slot. Depends on krbt_pkg.
`default_nettype none

module krbt_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire krbt_pkg::t_dp_stat i_stat,
    output krbt_pkg::t_dp_cmd       o_cmd
);
    import krbt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_rekey_2nd;
    logic   n_rekey_2nd;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rekey_2nd <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rekey_2nd <= n_rekey_2nd;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_rekey_2nd = r_rekey_2nd;
        o_cmd       = '0;
        o_in_ready  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_state      = S_DECODE;
                end
            end

            S_DECODE: begin
                n_rekey_2nd = 1'b0;
                n_state     = S_FIN;
                unique case (i_stat.cmd)
                    CMD_PUSH: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_ZERO;
                        if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.wr_key     = 1'b1;
                            o_cmd.wr_pay     = 1'b1;
                            o_cmd.wr_src     = WS_INPUT;
                            o_cmd.push_adv   = 1'b1;
                        end
                    end
                    CMD_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                            o_cmd.res_sel    = RES_ZERO;
                        end else begin
                            o_cmd.rd_en   = 1'b1;
                            o_cmd.rd_sel  = RD_RSLOT;
                            o_cmd.pop_adv = 1'b1;
                            n_state       = S_LOAD_RD;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_stat.empty) begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_EMPTY;
                            o_cmd.res_sel    = RES_ZERO;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        o_cmd.clear      = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_sel    = RES_ZERO;
                    end
                    default: begin
                        // add, lookup, update, rekey: search for key first
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN_RD;
                    end
                endcase
            end

            // issue the read of the next slot, or finish a failed search
            S_SCAN_RD: begin
                if (i_stat.scan_done) begin
                    n_state        = S_FIN;
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_ZERO;
                    priority if (i_stat.cmd == CMD_ADD) begin
                        if (i_stat.full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.res_status = ST_OK;
                            o_cmd.wr_key     = 1'b1;
                            o_cmd.wr_pay     = 1'b1;
                            o_cmd.wr_src     = WS_INPUT;
                            o_cmd.push_adv   = 1'b1;
                        end
                    end else if (i_stat.cmd == CMD_REKEY && r_rekey_2nd) begin
                        // new key absent: rename the hit entry
                        o_cmd.res_load = 1'b0;
                        o_cmd.wr_key   = 1'b1;
                        o_cmd.wr_at_hit = 1'b1;
                        o_cmd.wr_src   = WS_NKEY;
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.rd_sel   = RD_HIT;
                        n_state        = S_LOAD_NKEY;
                    end else begin
                        o_cmd.res_status = ST_NOTFOUND;
                    end
                end else begin
                    o_cmd.rd_en     = 1'b1;
                    o_cmd.rd_sel    = RD_SCAN;
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SCAN_CMP;
                end
            end

            // compare the key just read
            S_SCAN_CMP: begin
                if (!i_stat.match) begin
                    n_state = S_SCAN_RD;
                end else if (i_stat.cmd == CMD_REKEY && r_rekey_2nd) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_DUP;
                    o_cmd.res_sel    = RES_ZERO;
                    n_state          = S_FIN;
                end else begin
                    o_cmd.hit_latch = 1'b1;
                    unique case (i_stat.cmd)
                        CMD_LOOKUP: n_state = S_LK_RD;
                        CMD_UPDATE: n_state = S_UPD_WR;
                        CMD_DELETE: n_state = S_DEL_RD_HIT;
                        CMD_REKEY: begin
                            n_rekey_2nd      = 1'b1;
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_nkey  = 1'b1;
                            n_state          = S_SCAN_RD;
                        end
                        default: begin
                            // add unique with the key present
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_DUP;
                            o_cmd.res_sel    = RES_ZERO;
                            n_state          = S_FIN;
                        end
                    endcase
                end
            end

            S_LK_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HIT;
                n_state      = S_LOAD_RD;
            end

            S_LOAD_RD: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_sel    = RES_RD;
                n_state          = S_FIN;
            end

            S_UPD_WR: begin
                o_cmd.wr_pay     = 1'b1;
                o_cmd.wr_at_hit  = 1'b1;
                o_cmd.wr_src     = WS_INPUT;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_sel    = RES_KEY_PAY;
                n_state          = S_FIN;
            end

            S_DEL_RD_HIT: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HIT;
                n_state      = S_DEL_RD_OLD;
            end

            // latch the deleted entry, fetch the oldest one
            S_DEL_RD_OLD: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_sel    = RES_RD;
                o_cmd.rd_en      = 1'b1;
                o_cmd.rd_sel     = RD_RSLOT;
                n_state          = S_DEL_WR;
            end

            // oldest entry over the hit slot, then drop the oldest
            S_DEL_WR: begin
                o_cmd.wr_key    = 1'b1;
                o_cmd.wr_pay    = 1'b1;
                o_cmd.wr_at_hit = 1'b1;
                o_cmd.wr_src    = WS_READ;
                o_cmd.pop_adv   = 1'b1;
                n_state         = S_FIN;
            end

            S_LOAD_NKEY: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = ST_OK;
                o_cmd.res_sel    = RES_NKEY_RD;
                n_state          = S_FIN;
            end

            // hand the result to the output register once it is free
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/keyed_ring_buffer_table_core.sv @@
// keyed_ring_buffer_table_core: top level of the keyed ring buffer table.
// Instantiates krbt_ctrl and krbt_dp; depends on krbt_pkg.
//
// Usage
//   Command beats enter on s_axis_*, one result beat per command leaves on
//   m_axis_*. The depth register (i_cfg_we/i_cfg_wdata) is written while
//   the block is idle and takes effect at the next clear command.
//   One command is worked at a time. The controller returns to idle, ready
//   for the next command, as it loads the result into the output register.
//   A key search reads one stored key and then compares it, slot by slot
//   from the oldest entry, through the single read port of the key store,
//   so throughput falls with occupancy.
//   At reset the queue is empty, the depth register is 16 and the stores
//   keep no defined contents. A stalled result beat holds in the output
//   register; the next command is accepted meanwhile and its result waits
//   until the held beat is taken.
`default_nettype none

module keyed_ring_buffer_table_core #(
    parameter int DEPTH = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // cmd[2:0], key[18:3], new_key[34:19], payload[66:35], zero fill
    input  wire logic [krbt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // status[2:0], out_key[18:3], out_payload[50:19], occupancy[55:51]
    output logic [krbt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            i_cfg_we,
    input  wire logic [krbt_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import krbt_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // command sequencer
    krbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // stores, pointers and output register
    krbt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tdata  (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire

@@ hdl/krbt_checker.sv @@
// krbt_checker: port-level assertions for keyed_ring_buffer_table_core,
// attached by the bind at the end of this file. Depends on krbt_pkg.
`default_nettype none

module krbt_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic [krbt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready
);
    import krbt_pkg::*;

    logic [ST_W-1:0]  chk_status;
    logic [KEY_W-1:0] chk_key;
    logic [PAY_W-1:0] chk_pay;
    logic [OCC_W-1:0] chk_occ;

    assign chk_status = m_axis_tdata[OUT_ST_LSB +: ST_W];
    assign chk_key    = m_axis_tdata[OUT_KEY_LSB +: KEY_W];
    assign chk_pay    = m_axis_tdata[OUT_PAY_LSB +: PAY_W];
    assign chk_occ    = m_axis_tdata[OUT_OCC_LSB +: OCC_W];

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // reset leaves no result pending
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // occupancy never beyond the store
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (int'(chk_occ) <= DEPTH))
        else $error("occupancy beyond depth");

    // every reported status is a defined one, below ST_UNKNOWN
    a_status_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (chk_status < ST_UNKNOWN))
        else $error("unknown status reported");

    // refused commands carry no entry
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (chk_status != ST_OK) |-> (chk_key == '0) && (chk_pay == '0))
        else $error("refused command returned an entry");

endmodule

bind keyed_ring_buffer_table_core krbt_checker #(
    .DEPTH (DEPTH)
) u_krbt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

`default_nettype wire

@@ dv/tb_keyed_ring_buffer_table_core.sv @@
// tb_keyed_ring_buffer_table_core: self-checking testbench for the keyed ring buffer table.
// A directed table and random phases at several depths; rows without listed results are
// scored against a behavioural queue. Depends on krbt_pkg and keyed_ring_buffer_table_core.
`timescale 1ns / 100ps

module tb_keyed_ring_buffer_table_core;

    import krbt_pkg::*;

    localparam int SLOTS       = 16;
    localparam int KEY_POOL_SZ = 24;
    localparam int PHASE_ITEMS = 100;
    localparam int N_PHASES    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    // one command beat and one result beat, in the block's own widths
    typedef struct packed {
        t_cmd             cmd;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] new_key;
        logic [PAY_W-1:0] payload;
    } request_t;

    typedef struct packed {
        t_status          status;
        logic [KEY_W-1:0] out_key;
        logic [PAY_W-1:0] out_payload;
        logic [OCC_W-1:0] occupancy;
    } response_t;

    // one row of the directed table: either a depth write or a command
    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_val;
        request_t         rq;
        bit               typed;
        response_t        want;
    } plan_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic                   i_cfg_we;
    logic [CFG_W-1:0]       i_cfg_wdata;

    keyed_ring_buffer_table_core #(
        .DEPTH(SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // shadow copy of the queue
    logic [KEY_W-1:0] shadow_key [SLOTS];
    logic [PAY_W-1:0] shadow_pay [SLOTS];
    int unsigned      rd_ptr;
    int unsigned      wr_ptr;
    int unsigned      held;
    int unsigned      depth_setting;
    int unsigned      live_depth;

    response_t        results_due [$];
    logic [KEY_W-1:0] key_pool [KEY_POOL_SZ];
    plan_row_t        plan [$];

    int src_mode;
    int sink_mode;
    int fail_count;
    int n_checked;
    int n_sent;
    int n_cfg;
    int st_seen [6];
    int cycles = 0;

    // ---------------------------------------------------------------- queue predictor

    function automatic int unsigned clamp_depth(int unsigned d);
        if (d < 1) return 1;
        if (d > SLOTS) return SLOTS;
        return d;
    endfunction

    function automatic int unsigned wrap_next(int unsigned s);
        return (s + 1 >= live_depth) ? 0 : s + 1;
    endfunction

    // oldest-first search, -1 on a miss
    function automatic int find_oldest(logic [KEY_W-1:0] k);
        int unsigned s;
        s = rd_ptr;
        for (int unsigned i = 0; i < held; i++) begin
            if (shadow_key[s] == k) return int'(s);
            s = wrap_next(s);
        end
        return -1;
    endfunction

    function automatic t_status store_entry(logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
        if (held >= live_depth) return ST_FULL;
        shadow_key[wr_ptr] = k;
        shadow_pay[wr_ptr] = p;
        held++;
        wr_ptr = wrap_next(wr_ptr);
        return ST_OK;
    endfunction

    function automatic response_t apply_cmd(request_t rq);
        response_t r;
        int        hit;
        r = '{status: ST_OK, out_key: '0, out_payload: '0, occupancy: '0};
        case (rq.cmd)
            CMD_PUSH: begin
                r.status = store_entry(rq.key, rq.payload);
            end
            CMD_POP: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.out_key     = shadow_key[rd_ptr];
                    r.out_payload = shadow_pay[rd_ptr];
                    held--;
                    rd_ptr = wrap_next(rd_ptr);
                end
            end
            CMD_ADD: begin
                if (find_oldest(rq.key) >= 0) r.status = ST_DUP;
                else r.status = store_entry(rq.key, rq.payload);
            end
            CMD_LOOKUP: begin
                hit = find_oldest(rq.key);
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    r.out_key     = shadow_key[hit];
                    r.out_payload = shadow_pay[hit];
                end
            end
            CMD_DELETE: begin
                hit = find_oldest(rq.key);
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    // oldest entry moves into the hole, then the oldest slot is dropped
                    r.out_key       = shadow_key[hit];
                    r.out_payload   = shadow_pay[hit];
                    shadow_key[hit] = shadow_key[rd_ptr];
                    shadow_pay[hit] = shadow_pay[rd_ptr];
                    held--;
                    rd_ptr = wrap_next(rd_ptr);
                end
            end
            CMD_UPDATE: begin
                hit = find_oldest(rq.key);
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    shadow_pay[hit] = rq.payload;
                    r.out_key       = shadow_key[hit];
                    r.out_payload   = rq.payload;
                end
            end
            CMD_REKEY: begin
                hit = find_oldest(rq.key);
                if (hit < 0) begin
                    r.status = ST_NOTFOUND;
                end else if (find_oldest(rq.new_key) >= 0) begin
                    // also refused when the new key is the entry's own key
                    r.status = ST_DUP;
                end else begin
                    shadow_key[hit] = rq.new_key;
                    r.out_key       = rq.new_key;
                    r.out_payload   = shadow_pay[hit];
                end
            end
            default: begin
                rd_ptr     = 0;
                wr_ptr     = 0;
                held       = 0;
                live_depth = clamp_depth(depth_setting);
            end
        endcase
        r.occupancy = held[OCC_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // idle cycles before a beat: none, heavy, or occasional
    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 13);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    // key from a held entry, the phase pool, or anywhere in the range
    function automatic logic [KEY_W-1:0] pick_key(bit from_table);
        int unsigned off;
        if (from_table && held > 0 && $urandom_range(0, 3) != 0) begin
            off = $urandom_range(0, held - 1);
            return shadow_key[(rd_ptr + off) % live_depth];
        end
        if ($urandom_range(0, 4) != 0) return key_pool[$urandom_range(0, KEY_POOL_SZ - 1)];
        return KEY_W'($urandom());
    endfunction

    function automatic plan_row_t cmd_row(t_cmd c, logic [KEY_W-1:0] k, logic [KEY_W-1:0] nk,
                                          logic [PAY_W-1:0] p, bit typed, t_status st,
                                          logic [KEY_W-1:0] ok, logic [PAY_W-1:0] op,
                                          logic [OCC_W-1:0] occ);
        plan_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_val = '0;
        row.rq      = '{cmd: c, key: k, new_key: nk, payload: p};
        row.typed   = typed;
        row.want    = '{status: st, out_key: ok, out_payload: op, occupancy: occ};
        return row;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_W-1:0] v);
        plan_row_t row;
        row         = cmd_row(CMD_CLEAR, '0, '0, '0, 1'b0, ST_OK, '0, '0, '0);
        row.is_cfg  = 1'b1;
        row.cfg_val = v;
        return row;
    endfunction

    // drive one command beat, queue its expected result at the accepting edge
    task automatic send_cmd(request_t rq, bit typed, response_t want);
        int                    gap;
        logic [IN_TDATA_W-1:0] beat;
        response_t             got;
        gap  = draw_wait(src_mode);
        beat = '0;
        beat[IN_CMD_LSB  +: CMD_W] = rq.cmd;
        beat[IN_KEY_LSB  +: KEY_W] = rq.key;
        beat[IN_NKEY_LSB +: KEY_W] = rq.new_key;
        beat[IN_PAY_LSB  +: PAY_W] = rq.payload;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= beat;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        got = apply_cmd(rq);
        results_due.push_back(typed ? want : got);
        n_sent++;
    endtask

    // depth write, only once the block has drained
    task automatic write_depth(logic [CFG_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wdata <= v;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        depth_setting = v;
        n_cfg++;
    endtask

    // ---------------------------------------------------------------- result checker

    task automatic check_beat(logic [OUT_TDATA_W-1:0] d);
        response_t exp_r;
        t_status   st;
        st = t_status'(d[OUT_ST_LSB +: ST_W]);
        n_checked++;
        if (int'(st) < 6) st_seen[int'(st)]++;
        if (results_due.size() == 0) begin
            $error("result beat with nothing outstanding: tdata %h", d);
            fail_count++;
        end else begin
            exp_r = results_due.pop_front();
            if (st != exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, st);
                fail_count++;
            end
            if (d[OUT_KEY_LSB +: KEY_W] != exp_r.out_key) begin
                $error("out_key: expected %h, got %h", exp_r.out_key, d[OUT_KEY_LSB +: KEY_W]);
                fail_count++;
            end
            if (d[OUT_PAY_LSB +: PAY_W] != exp_r.out_payload) begin
                $error("out_payload: expected %h, got %h",
                       exp_r.out_payload, d[OUT_PAY_LSB +: PAY_W]);
                fail_count++;
            end
            if (d[OUT_OCC_LSB +: OCC_W] != exp_r.occupancy) begin
                $error("occupancy: expected %0d, got %0d",
                       exp_r.occupancy, d[OUT_OCC_LSB +: OCC_W]);
                fail_count++;
            end
        end
    endtask

    // ---------------------------------------------------------------- clock and watchdog

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, results_due.size());
            $display("** keyed_ring_buffer_table_core: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------- result sink

    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = draw_wait(sink_mode);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            check_beat(m_axis_tdata);
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        request_t   rq;
        response_t  none;
        int         r;
        int         grow;
        logic [4:0] phase_depth [N_PHASES];

        s_axis_tdata  <= '0;
        s_axis_tvalid <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        i_rst_n       <= 1'b0;

        fail_count = 0;
        n_checked  = 0;
        n_sent     = 0;
        n_cfg      = 0;
        foreach (st_seen[i]) st_seen[i] = 0;
        foreach (shadow_key[i]) begin
            shadow_key[i] = '0;
            shadow_pay[i] = '0;
        end
        rd_ptr        = 0;
        wr_ptr        = 0;
        held          = 0;
        depth_setting = DEPTH_RST;
        live_depth    = clamp_depth(DEPTH_RST);
        src_mode      = 2;
        sink_mode     = 2;
        none          = '{status: ST_OK, out_key: '0, out_payload: '0, occupancy: '0};

        // directed: empty queue after reset, a two-slot queue, then depth zero acting as one
        plan.push_back(cfg_row(5'd2));
        plan.push_back(cmd_row(CMD_POP,    16'h0000, 16'h0000, 32'h0, 1, ST_EMPTY,    '0, '0, 0));
        plan.push_back(cmd_row(CMD_DELETE, 16'h0000, 16'h0000, 32'h0, 1, ST_EMPTY,    '0, '0, 0));
        plan.push_back(cmd_row(CMD_LOOKUP, 16'hFFFF, 16'h0000, 32'h0, 1, ST_NOTFOUND, '0, '0, 0));
        plan.push_back(cmd_row(CMD_UPDATE, 16'h0001, 16'h0000, 32'hFFFF_FFFF,
                               1, ST_NOTFOUND, '0, '0, 0));
        plan.push_back(cmd_row(CMD_REKEY,  16'h0001, 16'hFFFF, 32'h0, 1, ST_NOTFOUND, '0, '0, 0));
        plan.push_back(cmd_row(CMD_CLEAR,  16'h0000, 16'h0000, 32'h0, 1, ST_OK,       '0, '0, 0));
        plan.push_back(cmd_row(CMD_PUSH,   16'h0000, 16'h0000, 32'hFFFF_FFFF,
                               1, ST_OK, '0, '0, 1));
        plan.push_back(cmd_row(CMD_ADD,    16'hFFFF, 16'h0000, 32'h0, 1, ST_OK,       '0, '0, 2));
        plan.push_back(cmd_row(CMD_PUSH,   16'h1234, 16'h0000, 32'h1, 1, ST_FULL,     '0, '0, 2));
        // duplicate check wins over the full check
        plan.push_back(cmd_row(CMD_ADD,    16'h0000, 16'h0000, 32'h2, 1, ST_DUP,      '0, '0, 2));
        plan.push_back(cmd_row(CMD_ADD,    16'h5555, 16'h0000, 32'h3, 1, ST_FULL,     '0, '0, 2));
        plan.push_back(cmd_row(CMD_LOOKUP, 16'hFFFF, 16'h0000, 32'h0,
                               1, ST_OK, 16'hFFFF, 32'h0, 2));
        // rekey onto its own key, then onto another present key
        plan.push_back(cmd_row(CMD_REKEY,  16'h0000, 16'h0000, 32'h0, 1, ST_DUP,      '0, '0, 2));
        plan.push_back(cmd_row(CMD_REKEY,  16'h0000, 16'hFFFF, 32'h0, 1, ST_DUP,      '0, '0, 2));
        plan.push_back(cmd_row(CMD_REKEY,  16'h0000, 16'hABCD, 32'h0, 0, ST_OK, '0, '0, 0));
        plan.push_back(cmd_row(CMD_UPDATE, 16'hFFFF, 16'h0000, 32'hA5A5_A5A5,
                               0, ST_OK, '0, '0, 0));
        plan.push_back(cmd_row(CMD_DELETE, 16'hFFFF, 16'h0000, 32'h0, 0, ST_OK, '0, '0, 0));
        plan.push_back(cmd_row(CMD_POP,    16'h0000, 16'h0000, 32'h0, 0, ST_OK, '0, '0, 0));
        plan.push_back(cmd_row(CMD_PUSH,   16'h8001, 16'h0000, 32'h1234_5678,
                               0, ST_OK, '0, '0, 0));
        plan.push_back(cmd_row(CMD_DELETE, 16'h7777, 16'h0000, 32'h0, 0, ST_OK, '0, '0, 0));
        // new depth waits for a clear
        plan.push_back(cfg_row(5'd0));
        plan.push_back(cmd_row(CMD_PUSH,   16'h4242, 16'h0000, 32'h0, 0, ST_OK, '0, '0, 0));
        plan.push_back(cmd_row(CMD_CLEAR,  16'h0000, 16'h0000, 32'h0, 1, ST_OK,       '0, '0, 0));
        plan.push_back(cmd_row(CMD_PUSH,   16'hFFFF, 16'h0000, 32'h0, 1, ST_OK,       '0, '0, 1));
        plan.push_back(cmd_row(CMD_ADD,    16'h1111, 16'h0000, 32'h0, 1, ST_FULL,     '0, '0, 1));
        plan.push_back(cmd_row(CMD_POP,    16'h0000, 16'h0000, 32'h0,
                               1, ST_OK, 16'hFFFF, 32'h0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) write_depth(plan[i].cfg_val);
            else send_cmd(plan[i].rq, plan[i].typed, plan[i].want);
        end

        // random phases: upper and lower extremes of the depth register, then mid values
        phase_depth[0] = 5'd31;
        phase_depth[1] = 5'd1;
        phase_depth[2] = 5'd0;
        phase_depth[3] = 5'd16;
        phase_depth[4] = 5'($urandom_range(2, 15));
        phase_depth[5] = 5'($urandom_range(2, 15));

        for (int p = 0; p < N_PHASES; p++) begin
            write_depth(phase_depth[p]);
            src_mode  = p % 3;
            sink_mode = (p + 1 + $urandom_range(0, 1)) % 3;
            foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom());
            key_pool[0] = '0;
            key_pool[1] = '1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                rq.payload = PAY_W'($urandom());
                rq.new_key = pick_key($urandom_range(0, 2) == 0);
                if (n == 0) begin
                    rq.cmd = CMD_CLEAR;
                end else begin
                    r    = $urandom_range(0, 99);
                    grow = (held * 2 < live_depth) ? 55 : 30;
                    if (r == 0) rq.cmd = CMD_CLEAR;
                    else if (r <= grow) rq.cmd = $urandom_range(0, 1) ? CMD_PUSH : CMD_ADD;
                    else begin
                        case ($urandom_range(0, 4))
                            0:       rq.cmd = CMD_POP;
                            1:       rq.cmd = CMD_LOOKUP;
                            2:       rq.cmd = CMD_DELETE;
                            3:       rq.cmd = CMD_UPDATE;
                            default: rq.cmd = CMD_REKEY;
                        endcase
                    end
                end
                case (rq.cmd)
                    CMD_PUSH: rq.key = pick_key(1'b0);
                    CMD_ADD:  rq.key = pick_key($urandom_range(0, 2) == 0);
                    default:  rq.key = pick_key(1'b1);
                endcase
                send_cmd(rq, 1'b0, none);
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d commands over %0d depth settings, %0d result beats scored, %0d errors.",
                 n_sent, n_cfg, n_checked, fail_count);
        $display("Status mix: ok %0d, full %0d, empty %0d, not found %0d, duplicate %0d.",
                 st_seen[ST_OK], st_seen[ST_FULL], st_seen[ST_EMPTY],
                 st_seen[ST_NOTFOUND], st_seen[ST_DUP]);
        if (fail_count == 0) begin
            $display("** keyed_ring_buffer_table_core: PASSED **");
        end else begin
            $display("** keyed_ring_buffer_table_core: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/krbt_pkg.sv
hdl/krbt_dp.sv
hdl/krbt_ctrl.sv
hdl/keyed_ring_buffer_table_core.sv
hdl/krbt_checker.sv
dv/tb_keyed_ring_buffer_table_core.sv
